// ===== hdl/lbd_pkg.sv =====
// Shared types and constants for the label boundary detect unit.
// Holds the request, response and command structs and the register codes.
// No dependencies.
package lbd_pkg;

   localparam int LABEL_BITS         = 32;
   localparam int COLUMN_BITS        = 11;
   localparam int ROW_BITS           = 16;
   localparam int WIDTH_REG_BITS     = 12;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int CSR_DATA_BITS      = 16;
   localparam int MAX_ROW_PIXELS_DEF = 2048;
   localparam int CMD_QUEUE_DEPTH    = 4;
   localparam int RSP_QUEUE_DEPTH    = 2;

   localparam logic [WIDTH_REG_BITS-1:0] RESET_FRAME_WIDTH  = 12'd1536;
   localparam logic [ROW_BITS-1:0]       RESET_FRAME_HEIGHT = 16'd1536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic signed [LABEL_BITS-1:0] label_type;

   typedef struct packed {
      logic      operation;
      label_type pixel_label;
   } req_type;

   typedef struct packed {
      logic                   is_boundary;
      label_type              centre_label;
      logic [COLUMN_BITS-1:0] out_column;
      logic [ROW_BITS-1:0]    out_row;
      logic                   frame_end;
   } rsp_type;

   typedef struct packed {
      logic                flush;
      label_type           label;
      logic [ROW_BITS-1:0] out_row;
      logic                has_result;
      logic                has_left;
      logic                has_right;
      logic                has_up;
      logic                frame_end;
   } cmd_type;

endpackage

// ===== hdl/lbd_ram.sv =====
// Generic simple dual-port RAM: one write port and two registered read ports.
// Read during write at the same address returns the old contents.
// No dependencies.
module lbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== hdl/lbd_queue.sv =====
// Small register-based FIFO used as the command queue and the result buffer.
// Full and empty come from registered state only.
// No dependencies.
module lbd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
      logic [AW-1:0] nxt;
      nxt = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNTW'(DEPTH));

endmodule

// ===== hdl/lbd_front.sv =====
// Front end: configuration registers, raster position counters and item
// classification into commands for the back end. Uses lbd_pkg.
module lbd_front #(
   parameter int MAX_ROW_PIXELS = lbd_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lbd_pkg::req_type                   req_payload,
   input  logic                               q_full,
   output logic                               cmd_push,
   output lbd_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_ROW_PIXELS)-1:0]  cmd_col
);

   import lbd_pkg::*;

   localparam int CW = $clog2(MAX_ROW_PIXELS);
   localparam int WW = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;

   logic [WIDTH_REG_BITS-1:0] frame_width_ff, frame_width_in;
   logic [ROW_BITS-1:0]       frame_height_ff, frame_height_in;
   logic [CW-1:0]             column_ff, column_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;

   logic [WW-1:0]       width_ext;
   logic [WW-1:0]       width_eff;
   logic [WW-1:0]       width_last;
   logic [WW-1:0]       col_next;
   logic [CW-1:0]       col;
   logic [ROW_BITS-1:0] height_eff;
   logic                flush;
   logic                ignore;
   logic                last;
   logic                accept;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext = WW'(frame_width_ff);
      if (width_ext == '0) begin
         width_eff = WW'(1);
      end else if (width_ext > WW'(MAX_ROW_PIXELS)) begin
         width_eff = WW'(MAX_ROW_PIXELS);
      end else begin
         width_eff = width_ext;
      end
      width_last = width_eff - 1'b1;
      height_eff = (frame_height_ff == '0) ? ROW_BITS'(1) : frame_height_ff;

      col      = (WW'(column_ff) >= width_eff) ? width_last[CW-1:0] : column_ff;
      col_next = WW'(col) + 1'b1;
      last     = (col_next >= width_eff);

      flush  = req_payload.operation;
      ignore = flush ? (row_ff == '0) : (row_ff >= height_eff);
      accept = req_valid && !q_full;

      req_stall = q_full;
      cmd_push  = accept && !ignore;

      cmd.flush      = flush;
      cmd.label      = req_payload.pixel_label;
      cmd.out_row    = row_ff - 1'b1;
      cmd.has_result = (row_ff != '0);
      cmd.has_left   = (col != '0);
      cmd.has_right  = !last;
      cmd.has_up     = (row_ff > ROW_BITS'(1));
      cmd.frame_end  = flush && last;
      cmd_col        = col;

      column_in = column_ff;
      row_in    = row_ff;
      if (cmd_push) begin
         if (last) begin
            column_in = '0;
            row_in    = flush ? '0 : row_ff + 1'b1;
         end else begin
            column_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         column_ff       <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
      end
   end

endmodule

// ===== hdl/lbd_back.sv =====
// Back end: row stores, neighbor compare with write forwarding, and the
// result buffer. Uses lbd_pkg, lbd_ram and lbd_queue.
module lbd_back #(
   parameter int MAX_ROW_PIXELS = lbd_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   input  lbd_pkg::cmd_type                  q_cmd,
   input  logic [$clog2(MAX_ROW_PIXELS)-1:0] q_col,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lbd_pkg::rsp_type                  rsp_payload
);

   import lbd_pkg::*;

   localparam int CW = $clog2(MAX_ROW_PIXELS);

   logic          b_vld_ff, b_vld_in;
   cmd_type       b_cmd_ff;
   logic [CW-1:0] b_col_ff;
   logic          fwd_a_ff, fwd_b_ff;
   label_type     fwd_mid_ff, fwd_up_ff;
   label_type     last_mid_ff;

   logic          issue;
   logic          b_done;
   logic [CW:0]   col_plus;
   logic          fwd_a_in, fwd_b_in;
   label_type     mid_rd_a, mid_rd_b, up_rd;
   label_type     mid, right, up, wr_mid;
   logic          bnd;
   logic          out_full;
   logic          out_push;
   rsp_type       rsp_in;
   logic [CW+COLUMN_BITS-1:0] col_wide;

   assign col_plus = {1'b0, q_col} + 1'b1;
   assign b_done   = b_vld_ff && !out_full;
   assign issue    = q_not_empty && (!b_vld_ff || b_done);
   assign q_pop    = issue;

   assign mid    = fwd_a_ff ? fwd_mid_ff : mid_rd_a;
   assign up     = fwd_a_ff ? fwd_up_ff  : up_rd;
   assign right  = fwd_b_ff ? fwd_mid_ff : mid_rd_b;
   assign wr_mid = b_cmd_ff.flush ? '0 : b_cmd_ff.label;

   assign fwd_a_in = b_done && (b_col_ff == q_col);
   assign fwd_b_in = b_done && (b_col_ff == col_plus[CW-1:0]);

   lbd_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_ROW_PIXELS)
   ) u_middle_row_store (
      .clock   (clock),
      .we      (b_done),
      .waddr   (b_col_ff),
      .wdata   (wr_mid),
      .re      (issue),
      .raddr_a (q_col),
      .raddr_b (col_plus[CW-1:0]),
      .rdata_a (mid_rd_a),
      .rdata_b (mid_rd_b)
   );

   lbd_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_ROW_PIXELS)
   ) u_upper_row_store (
      .clock   (clock),
      .we      (b_done),
      .waddr   (b_col_ff),
      .wdata   (mid),
      .re      (issue),
      .raddr_a (q_col),
      .raddr_b (q_col),
      .rdata_a (up_rd),
      .rdata_b ()
   );

   always_comb begin
      bnd = 1'b0;
      if (mid != '0) begin
         bnd = (b_cmd_ff.has_left && (last_mid_ff != mid))
            || (b_cmd_ff.has_right && (right != mid))
            || (b_cmd_ff.has_up && (up != mid))
            || (!b_cmd_ff.flush && (b_cmd_ff.label != mid));
      end
      col_wide            = {{COLUMN_BITS{1'b0}}, b_col_ff};
      rsp_in.is_boundary  = bnd;
      rsp_in.centre_label = mid;
      rsp_in.out_column   = col_wide[COLUMN_BITS-1:0];
      rsp_in.out_row      = b_cmd_ff.out_row;
      rsp_in.frame_end    = b_cmd_ff.frame_end;
      out_push            = b_done && b_cmd_ff.has_result;

      b_vld_in = b_vld_ff;
      if (issue) begin
         b_vld_in = 1'b1;
      end else if (b_done) begin
         b_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_cmd_ff   <= q_cmd;
         b_col_ff   <= q_col;
         fwd_a_ff   <= fwd_a_in;
         fwd_b_ff   <= fwd_b_in;
         fwd_mid_ff <= wr_mid;
         fwd_up_ff  <= mid;
      end
      if (b_done) begin
         last_mid_ff <= mid;
      end
   end

   lbd_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (rsp_in),
      .pop       (rsp_valid && !rsp_stall),
      .pop_data  (rsp_payload),
      .not_empty (rsp_valid),
      .full      (out_full)
   );

endmodule

// ===== hdl/label_boundary_detect_unit.sv =====
// Top level of the label boundary detect unit.
// Uses lbd_pkg, lbd_front, lbd_queue and lbd_back.
//
// Labels enter in raster order on the req_ channel, one transfer per pixel;
// after the last row the host sends frame_width flush transfers. Each result
// on the rsp_ channel describes the pixel one row above the input that
// caused it, and marks it as a boundary when its label is nonzero and an
// in-frame 4-neighbor holds a different label. Inputs of the first row give
// no result; inputs past the frame height, and flushes at row zero, are
// dropped. The user must write frame_width and frame_height on the csr_ port
// only while the block is idle; the block itself does not enforce this.
// A result reaches rsp_valid through the command queue, the back-end stage
// register and the result buffer, and the block sustains one transfer per cycle
// while the receiver does not stall, set by the two read ports of the middle
// row store that fetch a pixel and its right neighbor in the same cycle.
// Reset clears the position counters and sets both registers to 1536; the
// row stores are not cleared, since the first row is written before it is
// read. When the receiver stalls, a two-entry result buffer and a four-entry
// command queue fill, and then req_stall rises.
module label_boundary_detect_unit #(
   parameter int MAX_ROW_PIXELS = lbd_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lbd_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lbd_pkg::rsp_type                   rsp_payload
);

   import lbd_pkg::*;

   localparam int CW = $clog2(MAX_ROW_PIXELS);
   localparam int QW = $bits(cmd_type) + CW;

   logic          cmd_push;
   cmd_type       cmd;
   logic [CW-1:0] cmd_col;
   logic          q_full;
   logic          q_not_empty;
   logic          q_pop;
   logic [QW-1:0] q_data;
   cmd_type       q_cmd;
   logic [CW-1:0] q_col;

   lbd_front #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .cmd_push    (cmd_push),
      .cmd         (cmd),
      .cmd_col     (cmd_col)
   );

   lbd_queue #(
      .WIDTH (QW),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({cmd, cmd_col}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   assign q_cmd = cmd_type'(q_data[QW-1:CW]);
   assign q_col = q_data[CW-1:0];

   lbd_back #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (q_cmd),
      .q_col       (q_col),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for label_boundary_detect_unit: it streams label frames, tracks the
// row stores and position in a predictor, and compares every result transfer with the oldest
// expected boundary mark. Depends on lbd_pkg and the unit's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbd_pkg::*;

   localparam int MAX_PIXELS    = MAX_ROW_PIXELS_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PHASE_ITEMS   = 400;
   localparam logic OP_PIXEL    = 1'b0;
   localparam logic OP_FLUSH    = 1'b1;
   localparam label_type LABEL_MIN = 32'sh8000_0000;
   localparam label_type LABEL_MAX = 32'sh7FFF_FFFF;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_we      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_type                   rsp_payload;

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int fail_count      = 0;
   int processed_items = 0;
   int cycle_count     = 0;

   logic [WIDTH_REG_BITS-1:0] frame_width_reg;
   logic [ROW_BITS-1:0]       frame_height_reg;
   label_type                 upper_labels [MAX_PIXELS];
   label_type                 middle_labels [MAX_PIXELS];
   int                        next_column;
   int                        next_row;
   label_type                 left_neighbor;
   rsp_type                   pending_marks [$];

   label_boundary_detect_unit i_dut (
      .clock,
      .reset,
      .csr_we,
      .csr_index,
      .csr_wdata,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_payload
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic int active_width();
      if (frame_width_reg == 0) return 1;
      if (frame_width_reg > MAX_PIXELS) return MAX_PIXELS;
      return frame_width_reg;
   endfunction

   function automatic bit mark_pixel(req_type item);
      int        w;
      int        h;
      int        col;
      label_type centre;
      rsp_type   mark;
      w = active_width();
      h = (frame_height_reg == 0) ? 1 : frame_height_reg;
      col = (next_column >= w) ? w - 1 : next_column;
      if ((item.operation == OP_FLUSH) ? (next_row == 0) : (next_row >= h)) return 1'b0;
      centre = middle_labels[col];
      if (next_row >= 1) begin
         mark.is_boundary = 1'b0;
         if (centre != 0) begin
            if (col > 0 && left_neighbor != centre) mark.is_boundary = 1'b1;
            if (col + 1 < w && middle_labels[col + 1] != centre) mark.is_boundary = 1'b1;
            if (next_row > 1 && upper_labels[col] != centre) mark.is_boundary = 1'b1;
            if (item.operation == OP_PIXEL && item.pixel_label != centre) begin
               mark.is_boundary = 1'b1;
            end
         end
         mark.centre_label = centre;
         mark.out_column   = COLUMN_BITS'(col);
         mark.out_row      = ROW_BITS'(next_row - 1);
         mark.frame_end    = (item.operation == OP_FLUSH && col + 1 >= w);
         pending_marks.push_back(mark);
      end
      upper_labels[col]  = centre;
      middle_labels[col] = (item.operation == OP_FLUSH) ? '0 : item.pixel_label;
      left_neighbor      = centre;
      if (col + 1 >= w) begin
         next_column   = 0;
         left_neighbor = '0;
         next_row      = (item.operation == OP_FLUSH) ? 0 : next_row + 1;
      end else begin
         next_column = col + 1;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_marks.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, rsp_payload);
            fail_count++;
         end else begin
            want = pending_marks.pop_front();
            check_field("is_boundary", want.is_boundary, rsp_payload.is_boundary);
            check_field("centre_label", want.centre_label, rsp_payload.centre_label);
            check_field("out_column", want.out_column, rsp_payload.out_column);
            check_field("out_row", want.out_row, rsp_payload.out_row);
            check_field("frame_end", want.frame_end, rsp_payload.frame_end);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_item(input logic op, input label_type label);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, pixel_label: label};
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (mark_pixel(req_payload)) processed_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_marks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_frame(input logic [CSR_DATA_BITS-1:0] width_value,
                                  input logic [CSR_DATA_BITS-1:0] height_value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width_value;
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= height_value;
      @(negedge clock);
      csr_we <= 1'b0;
      frame_width_reg  = width_value[WIDTH_REG_BITS-1:0];
      frame_height_reg = height_value;
   endtask

   function automatic label_type pick_label(label_type left, label_type above);
      case ($urandom_range(11))
         0, 1:    return '0;
         2, 3, 4: return left;
         5, 6:    return above;
         7:       return ($urandom_range(1) == 1) ? LABEL_MIN : LABEL_MAX;
         8, 9:    return label_type'($urandom_range(3)) - 1;
         default: return label_type'($urandom());
      endcase
   endfunction

   task automatic send_frame(input int w, input int rows, input bit mixed);
      label_type row_labels [MAX_PIXELS] = '{default: '0};
      label_type label;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < w; c++) begin
            if (mixed && r > 0 && $urandom_range(7) == 0) begin
               send_item(OP_FLUSH, label_type'($urandom()));
            end else begin
               label = pick_label((c > 0) ? row_labels[c - 1] : '0, row_labels[c]);
               row_labels[c] = label;
               send_item(OP_PIXEL, label);
            end
         end
      end
      for (int c = 0; c < w; c++) send_item(OP_FLUSH, label_type'($urandom()));
   endtask

   task automatic test_directed_frame();
      configure_frame(16'd3, 16'd2);
      send_item(OP_FLUSH, LABEL_MAX);
      send_item(OP_PIXEL, LABEL_MIN);
      send_item(OP_PIXEL, '0);
      send_item(OP_PIXEL, LABEL_MAX);
      send_item(OP_PIXEL, LABEL_MAX);
      send_item(OP_PIXEL, -1);
      send_item(OP_PIXEL, -1);
      send_item(OP_PIXEL, 5);
      send_item(OP_FLUSH, -1);
      send_item(OP_FLUSH, LABEL_MIN);
      send_item(OP_FLUSH, '0);
   endtask

   task automatic test_mixed_row();
      configure_frame(16'd3, 16'd4);
      send_item(OP_PIXEL, 7);
      send_item(OP_PIXEL, 7);
      send_item(OP_PIXEL, 8);
      send_item(OP_PIXEL, 7);
      send_item(OP_FLUSH, 3);
      send_item(OP_PIXEL, 8);
      for (int c = 0; c < 3; c++) send_item(OP_FLUSH, '0);
   endtask

   task automatic test_width_narrowing();
      configure_frame(16'd4, 16'd3);
      send_item(OP_PIXEL, 1);
      send_item(OP_PIXEL, 2);
      send_item(OP_PIXEL, 2);
      send_item(OP_PIXEL, 3);
      send_item(OP_PIXEL, 1);
      send_item(OP_PIXEL, 1);
      configure_frame(16'd2, 16'd3);
      send_item(OP_PIXEL, 5);
      send_item(OP_PIXEL, 5);
      send_item(OP_PIXEL, 6);
      send_item(OP_FLUSH, '0);
      send_item(OP_FLUSH, '0);
   endtask

   task automatic test_register_extremes();
      configure_frame(16'd0, 16'd0);
      send_item(OP_FLUSH, '0);
      send_item(OP_PIXEL, 9);
      send_item(OP_PIXEL, 4);
      send_item(OP_FLUSH, '0);
      configure_frame(16'd2, 16'hFFFF);
      send_frame(2, 3, 1'b0);
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct, input int quota);
      int w;
      int h;
      int rows;
      int start;
      bit first;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = processed_items;
      first = 1'b1;
      while (processed_items - start < quota) begin
         if (first || $urandom_range(1) == 1) begin
            case ($urandom_range(19))
               0:          w = $urandom_range(41, 160);
               1, 2, 3, 4: w = $urandom_range(9, 40);
               default:    w = $urandom_range(1, 8);
            endcase
            h = $urandom_range(0, 5);
            configure_frame({4'($urandom()), 12'(w)}, 16'(h));
            first = 1'b0;
         end
         rows = ((h == 0) ? 1 : h) + (($urandom_range(3) == 0) ? 1 : 0);
         if ($urandom_range(4) == 0) send_item(OP_FLUSH, label_type'($urandom()));
         send_frame(w, rows, $urandom_range(3) == 0);
      end
   endtask

   initial begin
      frame_width_reg  = RESET_FRAME_WIDTH;
      frame_height_reg = RESET_FRAME_HEIGHT;
      next_column      = 0;
      next_row         = 0;
      left_neighbor    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      test_directed_frame();
      test_mixed_row();
      test_width_narrowing();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_register_extremes();
      test_random_frames(0, 0, PHASE_ITEMS);
      test_random_frames(79, 0, PHASE_ITEMS);
      test_random_frames(0, 79, PHASE_ITEMS);
      test_random_frames(24, 24, PHASE_ITEMS);
      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
